>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL of the framed message ring.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BFMR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFMR_ASSERT(lbl, prop, msg) \
  `BFMR_ASSERT_RST(lbl, clk_i, rst_ni, prop, msg)
`else
`define BFMR_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define BFMR_ASSERT(lbl, prop, msg)
`endif

`endif

>>> rtl/bfmr_pkg.sv
// Shared constants and controller/datapath command types of the framed message ring.
// No dependencies.
package bfmr_pkg;

  localparam int unsigned SlotCountDef = 8;
  localparam int unsigned SlotBytesDef = 16;

  localparam logic [7:0] StartCharRst = 8'h5B;  // '['
  localparam logic [7:0] EndCharRst   = 8'h5D;  // ']'

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [0:0] {
    REG_START_CHAR = 1'b0,
    REG_END_CHAR   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic accept;     // item taken this cycle
    logic init_step;  // post-reset clear sweep
    logic clr_step;   // clear one byte of the write slot
    logic pop_step;   // read one byte of the read slot
  } dp_cmd_t;

  typedef struct packed {
    logic go_pop;     // current item is a pop on a non-empty ring
    logic go_clear;   // current item needs a slot clear
    logic out_free;   // output register can take a byte
    logic walk_last;  // byte walk at final byte
    logic init_done;  // last entry of the reset sweep
  } dp_status_t;

endpackage

>>> rtl/bfmr_in_if.sv
// Input item channel: action and received byte with valid/ready.
// No dependencies.
interface bfmr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

>>> rtl/bfmr_out_if.sv
// Result item channel: popped byte and last flag with valid/ready.
// No dependencies.
interface bfmr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

>>> rtl/bfmr_regs.sv
// APB-style register file holding the start and end characters.
// Depends on bfmr_pkg.
module bfmr_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfmr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [bfmr_pkg::CfgDataW-1:0]  pwdata,
  output logic [bfmr_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready,
  output logic [7:0]                     start_char_o,
  output logic [7:0]                     end_char_o
);
  import bfmr_pkg::*;

  logic [7:0] start_char_q;
  logic [7:0] end_char_q;
  logic       wr_en;
  reg_idx_e   sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  // word aligned; only the word index bit decodes
  assign sel    = reg_idx_e'(paddr[CfgAddrW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= StartCharRst;
      end_char_q   <= EndCharRst;
    end else if (wr_en) begin
      unique case (sel)
        REG_START_CHAR: start_char_q <= pwdata[7:0];
        REG_END_CHAR:   end_char_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_START_CHAR: prdata = {(CfgDataW-8)'(0), start_char_q};
      REG_END_CHAR:   prdata = {(CfgDataW-8)'(0), end_char_q};
      default:        prdata = '0;
    endcase
  end

  assign start_char_o = start_char_q;
  assign end_char_o   = end_char_q;

endmodule

>>> rtl/bfmr_ctrl.sv
// Sequencer of the framed message ring: reset sweep, item intake, slot clear and pop walks.
// Depends on bfmr_pkg.
module bfmr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bfmr_pkg::dp_status_t  st_i,
  output bfmr_pkg::dp_cmd_t     cmd_o
);
  import bfmr_pkg::*;

  typedef enum logic [3:0] {
    S_INIT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CLEAR = 4'b0100,
    S_POP   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (st_i.init_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (st_i.go_pop) state_d = S_POP;
          else if (st_i.go_clear) state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.walk_last) state_d = S_IDLE;
      end
      S_POP: begin
        // a byte is read only when the output register frees up
        cmd_o.pop_step = st_i.out_free;
        if (st_i.out_free && st_i.walk_last) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/bfmr_dp.sv
// Datapath of the framed message ring: slot memory, ring pointers, frame state, output register.
// Depends on bfmr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bfmr_dp #(
  parameter int unsigned SLOT_COUNT = bfmr_pkg::SlotCountDef,
  parameter int unsigned SLOT_BYTES = bfmr_pkg::SlotBytesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  action_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [7:0]            start_char_i,
  input  logic [7:0]            end_char_i,
  input  bfmr_pkg::dp_cmd_t     cmd_i,
  output bfmr_pkg::dp_status_t  st_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_o
);
  import bfmr_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOT_COUNT);
  localparam int unsigned ByteW = $clog2(SLOT_BYTES);
  localparam int unsigned AddrW = SlotW + ByteW;
  localparam int unsigned Depth = SLOT_COUNT * (2 ** ByteW);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(SLOT_COUNT - 1);
  localparam logic [ByteW-1:0] ByteLast = ByteW'(SLOT_BYTES - 1);

  logic [7:0]       mem_q [Depth];
  logic [SlotW-1:0] write_slot_q;
  logic [SlotW-1:0] read_slot_q;
  logic [SlotW-1:0] init_slot_q;
  logic             wrapped_q;
  logic [ByteW-1:0] byte_count_q;
  logic             in_frame_q;
  logic [ByteW-1:0] walk_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             last_q;

  logic             is_start, is_end, is_data, overflow, empty;
  logic             rx_item, data_wr, mem_we, walk_en;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AddrW-1:0] mem_raddr;

  // start wins when both characters match
  assign is_start = (rx_byte_i == start_char_i);
  assign is_end   = !is_start && (rx_byte_i == end_char_i);
  assign is_data  = !is_start && !is_end && in_frame_q;
  assign overflow = is_data && (byte_count_q == ByteLast);
  assign empty    = (write_slot_q <= read_slot_q) && !wrapped_q;

  assign st_o.go_pop    = action_i && !empty;
  assign st_o.go_clear  = !action_i && (is_start || overflow);
  assign st_o.out_free  = !out_valid_q || out_ready_i;
  assign st_o.walk_last = (walk_q == ByteLast);
  assign st_o.init_done = st_o.walk_last && (init_slot_q == SlotLast);

  assign rx_item = cmd_i.accept && !action_i;
  // an overflowing byte is wiped by the clear that follows, so it is not stored
  assign data_wr = rx_item && is_data && !overflow;
  assign mem_we  = cmd_i.init_step || cmd_i.clr_step || data_wr;
  assign walk_en = cmd_i.init_step || cmd_i.clr_step || cmd_i.pop_step;

  always_comb begin
    mem_wdata = 8'h00;
    if (cmd_i.init_step) begin
      mem_waddr = {init_slot_q, walk_q};
    end else if (cmd_i.clr_step) begin
      mem_waddr = {write_slot_q, walk_q};
    end else begin
      mem_waddr = {write_slot_q, byte_count_q};
      mem_wdata = rx_byte_i;
    end
  end

  assign mem_raddr = {read_slot_q, walk_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (cmd_i.pop_step) begin
      out_byte_q <= mem_q[mem_raddr];
      last_q     <= st_o.walk_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= '0;
      read_slot_q  <= '0;
      init_slot_q  <= '0;
      wrapped_q    <= 1'b0;
      byte_count_q <= '0;
      in_frame_q   <= 1'b0;
      walk_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (rx_item) begin
        if (is_start) begin
          byte_count_q <= '0;
          in_frame_q   <= 1'b1;
        end else if (is_end) begin
          if (write_slot_q == SlotLast) begin
            write_slot_q <= '0;
            wrapped_q    <= 1'b1;
          end else begin
            write_slot_q <= write_slot_q + 1'b1;
          end
          byte_count_q <= '0;
          in_frame_q   <= 1'b0;
        end else if (is_data) begin
          byte_count_q <= overflow ? '0 : byte_count_q + 1'b1;
        end
      end

      if (walk_en) walk_q <= st_o.walk_last ? '0 : walk_q + 1'b1;

      if (cmd_i.init_step && st_o.walk_last && !st_o.init_done) begin
        init_slot_q <= init_slot_q + 1'b1;
      end

      if (cmd_i.pop_step && st_o.walk_last) begin
        if (read_slot_q == SlotLast) begin
          read_slot_q <= '0;
          wrapped_q   <= 1'b0;
        end else begin
          read_slot_q <= read_slot_q + 1'b1;
        end
      end

      if (cmd_i.pop_step) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  `BFMR_ASSERT(a_pop_room, cmd_i.pop_step |-> st_o.out_free, "pop read with output register full")
  `BFMR_ASSERT(a_last_flag, cmd_i.pop_step && st_o.walk_last |=> out_valid_q && last_q, "final byte of slot not flagged last")
  `BFMR_ASSERT(a_clear_slot_held, cmd_i.clr_step |=> $stable(write_slot_q), "write slot moved during slot clear")
  `BFMR_ASSERT(a_walk_at_rest, cmd_i.accept |-> walk_q == '0, "byte walk not at rest when item accepted")

endmodule

>>> rtl/bracket_framed_message_ring.sv
// Framed message ring: received bytes between start/end characters fill a ring of slots.
// A start byte or a slot overflow triggers a byte-wise clear of the write slot through the single
// memory write port; a pop reads the slot one byte per cycle from the registered memory read,
// holding while the output register is full; a pop on an empty ring gives no result.
// Reset is asynchronous, active low; a clearing pass over every byte of all SLOT_COUNT slots
// follows, during which no item is accepted (register writes are taken throughout).
module bracket_framed_message_ring #(
  parameter int unsigned SLOT_COUNT = bfmr_pkg::SlotCountDef,
  parameter int unsigned SLOT_BYTES = bfmr_pkg::SlotBytesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bfmr_in_if.sink                        in_if,
  bfmr_out_if.source                     out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfmr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [bfmr_pkg::CfgDataW-1:0]  pwdata,
  output logic [bfmr_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);
  import bfmr_pkg::*;

  logic       [7:0] start_char;
  logic       [7:0] end_char;
  dp_cmd_t          cmd;
  dp_status_t       st;

  bfmr_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start_char_o (start_char),
    .end_char_o   (end_char)
  );

  bfmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bfmr_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (in_if.action),
    .rx_byte_i    (in_if.rx_byte),
    .start_char_i (start_char),
    .end_char_i   (end_char),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_byte_o   (out_if.out_byte),
    .last_o       (out_if.last)
  );

endmodule
